/* rtl/bpc_pkg.sv */
package bpc_pkg;

  // default width of the press timer
  localparam int TimerBitsDef = 16;

  // result queue depth, must hold the two results of one item plus slack
  localparam int QDepth   = 4;
  localparam int QPtrBits = $clog2(QDepth);
  localparam int QCntBits = $clog2(QDepth + 1);

  // input opcodes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpEdge  = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;
  localparam logic [1:0] OpStop  = 2'd3;

  // report codes
  localparam logic [2:0] RptStartOk  = 3'd0;
  localparam logic [2:0] RptStartErr = 3'd1;
  localparam logic [2:0] RptStopOk   = 3'd2;
  localparam logic [2:0] RptActive   = 3'd3;
  localparam logic [2:0] RptInactive = 3'd4;
  localparam logic [2:0] RptPulse    = 3'd5;
  localparam logic [2:0] RptHold     = 3'd6;

  // configuration register indexes
  localparam logic [1:0] RegTrackingMode = 2'd0;
  localparam logic [1:0] RegActiveHigh   = 2'd1;
  localparam logic [1:0] RegPulseTicks   = 2'd2;
  localparam logic [1:0] RegHoldTicks    = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pin_level;
    logic       glitch_filter;
  } in_t;

  typedef struct packed {
    logic [2:0]  report;
    logic [15:0] hold_count;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        tracking_mode;
    logic        active_high;
    logic [15:0] pulse_ticks;
    logic [15:0] hold_ticks;
  } cfg_t;

  // zero, one or two results produced by one item
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } res_t;

endpackage

/* rtl/bpc_core.sv */
module bpc_core #(
  parameter int TimerBits = bpc_pkg::TimerBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  bpc_pkg::in_t   item_i,
  input  bpc_pkg::cfg_t  cfg_i,
  output bpc_pkg::res_t  res_o
);

  localparam logic [2:0] PhStopped   = 3'd0;
  localparam logic [2:0] PhTrigger   = 3'd1;
  localparam logic [2:0] PhInactive  = 3'd2;
  localparam logic [2:0] PhPulseWait = 3'd3;
  localparam logic [2:0] PhHoldWait  = 3'd4;
  localparam logic [2:0] PhHeld      = 3'd5;

  localparam logic [TimerBits-1:0] TimerZero = '0;
  localparam logic [TimerBits-1:0] TimerOne  = TimerBits'(1);

  logic [2:0]           phase_q, phase_d;
  logic                 filter_q, filter_d;
  logic [TimerBits-1:0] timer_q, timer_d;
  logic [15:0]          holds_q, holds_d;

  logic [31:0]          pulse_ext, hold_ext;
  logic [TimerBits-1:0] pulse_load, hold_load;
  logic                 act, expire;
  logic [15:0]          holds_inc;
  logic [1:0]           cnt;
  logic [2:0]           rpt0, rpt1;
  logic [15:0]          hcnt0;

  assign pulse_ext  = 32'(cfg_i.pulse_ticks);
  assign hold_ext   = 32'(cfg_i.hold_ticks);
  assign pulse_load = pulse_ext[TimerBits-1:0];
  assign hold_load  = hold_ext[TimerBits-1:0];
  assign act        = (item_i.pin_level == cfg_i.active_high);
  assign expire     = (timer_q <= TimerOne);
  assign holds_inc  = (holds_q == 16'hFFFF) ? holds_q : holds_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    filter_d = filter_q;
    timer_d  = timer_q;
    holds_d  = holds_q;
    cnt      = 2'd0;
    rpt0     = bpc_pkg::RptStartOk;
    rpt1     = bpc_pkg::RptStartOk;
    hcnt0    = 16'd0;
    case (item_i.opcode)
      bpc_pkg::OpTick: begin
        if (phase_q == PhPulseWait) begin
          if (expire) begin
            phase_d = PhHoldWait;
            timer_d = hold_load;
          end else begin
            timer_d = timer_q - TimerOne;
          end
        end else if (phase_q == PhHoldWait || phase_q == PhHeld) begin
          if (expire) begin
            holds_d = holds_inc;
            phase_d = PhHeld;
            timer_d = hold_load;
            cnt     = 2'd1;
            rpt0    = bpc_pkg::RptHold;
            hcnt0   = holds_inc;
          end else begin
            timer_d = timer_q - TimerOne;
          end
        end
      end
      bpc_pkg::OpEdge: begin
        if (phase_q == PhTrigger) begin
          cnt  = 2'd1;
          rpt0 = bpc_pkg::RptActive;
        end else if (phase_q == PhInactive) begin
          if (act) begin
            holds_d = 16'd0;
            phase_d = PhPulseWait;
            timer_d = pulse_load;
            cnt     = 2'd1;
            rpt0    = bpc_pkg::RptActive;
          end else if (!filter_q) begin
            timer_d = TimerZero;
            cnt     = 2'd1;
            rpt0    = bpc_pkg::RptInactive;
          end
        end else if (phase_q == PhPulseWait || phase_q == PhHoldWait ||
                     phase_q == PhHeld) begin
          if (!act) begin
            phase_d = PhInactive;
            timer_d = TimerZero;
            // release after the pulse time reports pulse first
            if (phase_q == PhHoldWait) begin
              cnt  = 2'd2;
              rpt0 = bpc_pkg::RptPulse;
              rpt1 = bpc_pkg::RptInactive;
            end else begin
              cnt  = 2'd1;
              rpt0 = bpc_pkg::RptInactive;
            end
          end else if (!filter_q) begin
            holds_d = 16'd0;
            phase_d = PhPulseWait;
            timer_d = pulse_load;
            cnt     = 2'd1;
            rpt0    = bpc_pkg::RptActive;
          end
        end
      end
      bpc_pkg::OpStart: begin
        if (phase_q != PhStopped) begin
          cnt  = 2'd1;
          rpt0 = bpc_pkg::RptStartErr;
        end else begin
          filter_d = item_i.glitch_filter;
          if (cfg_i.tracking_mode) begin
            cnt  = 2'd2;
            rpt0 = bpc_pkg::RptStartOk;
            if (act) begin
              holds_d = 16'd0;
              phase_d = PhPulseWait;
              timer_d = pulse_load;
              rpt1    = bpc_pkg::RptActive;
            end else begin
              phase_d = PhInactive;
              timer_d = TimerZero;
              rpt1    = bpc_pkg::RptInactive;
            end
          end else begin
            cnt     = 2'd1;
            rpt0    = bpc_pkg::RptStartOk;
            phase_d = PhTrigger;
            timer_d = TimerZero;
          end
        end
      end
      default: begin
        cnt     = 2'd1;
        rpt0    = bpc_pkg::RptStopOk;
        phase_d = PhStopped;
        timer_d = TimerZero;
      end
    endcase
  end

  always_comb begin
    res_o.count             = cnt;
    res_o.first.report      = rpt0;
    res_o.first.hold_count  = hcnt0;
    res_o.first.last        = (cnt == 2'd1);
    res_o.second.report     = rpt1;
    res_o.second.hold_count = 16'd0;
    res_o.second.last       = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhStopped;
      filter_q <= 1'b1;
      timer_q  <= TimerZero;
      holds_q  <= 16'd0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      filter_q <= filter_d;
      timer_q  <= timer_d;
      holds_q  <= holds_d;
    end
  end

  // timer only runs while waiting on a press
  a_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhStopped || phase_q == PhTrigger || phase_q == PhInactive)
      |-> timer_q == TimerZero)
    else $error("timer running outside a press");

  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHeld) |-> holds_q != 16'd0)
    else $error("held phase with zero hold count");

endmodule

/* rtl/bpc_outq.sv */
module bpc_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bpc_pkg::res_t  res_i,
  output logic           room_o,
  output logic           valid_o,
  input  logic           ready_i,
  output bpc_pkg::out_t  data_o
);

  localparam int Depth = bpc_pkg::QDepth;
  localparam int PB    = bpc_pkg::QPtrBits;
  localparam int CB    = bpc_pkg::QCntBits;

  bpc_pkg::out_t entry_q [Depth];
  logic [PB-1:0] head_q, head_d, tail_q, tail_d, tail_nx;
  logic [CB-1:0] count_q, count_d;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push  = push_i ? res_i.count : 2'd0;
  assign pop     = valid_o && ready_i;
  assign tail_nx = tail_q + PB'(1);
  assign room_o  = (count_q <= CB'(Depth - 2));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[head_q];
  assign head_d  = pop ? head_q + PB'(1) : head_q;
  assign tail_d  = tail_q + PB'(n_push);
  assign count_d = count_q + CB'(n_push) - CB'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      entry_q[tail_q] <= res_i.first;
    end
    if (n_push == 2'd2) begin
      entry_q[tail_nx] <= res_i.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> count_q + CB'(n_push) <= CB'(Depth))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CB'(Depth))
    else $error("result queue count out of range");

endmodule

/* rtl/button_press_classifier.sv */
// button press classifier
//
// input channel (in_valid_i / in_ready_o / in_data_i) carries tick, pin edge,
// start and stop items; output channel (out_valid_o / out_ready_i /
// out_data_o) carries reports, the last one of each item flagged by last.
// each item yields zero, one or two reports.
// the state update happens at the input transfer, and its reports are
// registered in a four-entry result queue ahead of the output.
// throughput: one item per cycle while the receiver takes one report per
// cycle and items give at most one report; items with two reports fill the
// queue faster than it drains, so a run of them is limited by the output side.
// in_ready_o is high whenever the queue has room for two reports, so with a
// stalled receiver input stops once three or four reports are waiting.
// configuration goes through the apb port (regs 0x0, 0x4, 0x8, 0xc); the user
// writes it only while the block is idle (not enforced); pready is tied high.
// reset: configuration returns to its defaults (tracking, active high,
// pulse 50 ticks, hold 1000 ticks), the block is stopped and the queue empty.
module button_press_classifier #(
  parameter int TimerBits = bpc_pkg::TimerBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // item input
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bpc_pkg::in_t  in_data_i,
  // report output
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bpc_pkg::out_t out_data_o,
  // configuration
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  bpc_pkg::cfg_t cfg_q;
  bpc_pkg::res_t res;
  logic          take;
  logic          room;
  logic          wr_en;
  logic [1:0]    reg_idx;

  // apb register file, zero wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tracking_mode <= 1'b1;
      cfg_q.active_high   <= 1'b1;
      cfg_q.pulse_ticks   <= 16'd50;
      cfg_q.hold_ticks    <= 16'd1000;
    end else if (wr_en) begin
      case (reg_idx)
        bpc_pkg::RegTrackingMode: cfg_q.tracking_mode <= pwdata[0];
        bpc_pkg::RegActiveHigh:   cfg_q.active_high   <= pwdata[0];
        bpc_pkg::RegPulseTicks:   cfg_q.pulse_ticks   <= pwdata[15:0];
        bpc_pkg::RegHoldTicks:    cfg_q.hold_ticks    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bpc_pkg::RegTrackingMode: prdata = {31'd0, cfg_q.tracking_mode};
      bpc_pkg::RegActiveHigh:   prdata = {31'd0, cfg_q.active_high};
      bpc_pkg::RegPulseTicks:   prdata = {16'd0, cfg_q.pulse_ticks};
      bpc_pkg::RegHoldTicks:    prdata = {16'd0, cfg_q.hold_ticks};
      default:                  prdata = 32'd0;
    endcase
  end

  // input transfer: accepted only when both reports of an item fit
  assign in_ready_o = room;
  assign take       = in_valid_i && room;

  // classifier state and per-item report decode
  bpc_core #(
    .TimerBits (TimerBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // reports queue up and leave one per output transfer
  bpc_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .res_i   (res),
    .room_o  (room),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

  // an item is only taken with room for its reports
  a_take_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> room)
    else $error("item taken without queue room");

  // every accepted start produces at least one report next cycle
  a_start_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && in_data_i.opcode == bpc_pkg::OpStart) |=> out_valid_o)
    else $error("start produced no report");

endmodule
